// ===== rtl/lcdns_pkg.sv =====
package lcdns_pkg;

	// Operation codes on the operation port
	localparam logic [2:0] OP_COMMAND = 3'd0;
	localparam logic [2:0] OP_DATA    = 3'd1;
	localparam logic [2:0] OP_NIBBLE  = 3'd2;
	localparam logic [2:0] OP_INIT    = 3'd3;
	localparam logic [2:0] OP_GOTO    = 3'd4;
	localparam logic [2:0] OP_DIGITS  = 3'd5;
	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;

	// Job kinds held in the queue
	localparam logic [1:0] KIND_BYTE   = 2'd0;
	localparam logic [1:0] KIND_NIBBLE = 2'd1;
	localparam logic [1:0] KIND_INIT   = 2'd2;
	localparam logic [1:0] KIND_DIGITS = 2'd3;

	// Cursor mode codes; the spare code behaves as blink
	localparam logic [1:0] CMODE_HIDE      = 2'd0;
	localparam logic [1:0] CMODE_SHOW      = 2'd1;
	localparam logic [1:0] CMODE_BLINK     = 2'd2;
	localparam logic [1:0] CMODE_BLINK_ALT = 2'd3;

	// LCD instruction bytes
	localparam logic [7:0] ROW0_BASE      = 8'h80;
	localparam logic [7:0] ROW1_BASE      = 8'hC0;
	localparam logic [7:0] ROW2_BASE      = 8'h90;
	localparam logic [7:0] ROW3_BASE      = 8'hD0;
	localparam logic [7:0] FUNCTION_SET   = 8'h28;
	localparam logic [7:0] ENTRY_MODE     = 8'h06;
	localparam logic [7:0] CLEAR_DISPLAY  = 8'h01;
	localparam logic [7:0] DISPLAY_OFF_CUR = 8'h0C;
	localparam logic [7:0] DISPLAY_ON_CUR = 8'h0E;
	localparam logic [7:0] DISPLAY_BLINK  = 8'h0F;
	localparam logic [7:0] DIGIT_BASE     = 8'd48;

	// Wake-up nibbles
	localparam logic [3:0] WAKE_NIBBLE  = 4'h3;
	localparam logic [3:0] MODE4_NIBBLE = 4'h2;

	// Reciprocal of ten for an 8-bit dividend: q = (x * 205) >> 11
	localparam logic [7:0] RECIP_TEN  = 8'd205;
	localparam int         RECIP_SHIFT = 11;

	localparam int COLUMN_LIMIT_DEFAULT = 20;
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [1:0] kind;
		logic       rs;
		logic [7:0] byte_a;
		logic [7:0] byte_b;
	} lcdns_desc_t;

	function automatic logic [7:0] row_base(input logic [1:0] r);
		logic [7:0] b;
		case (r)
			2'd0: b = ROW0_BASE;
			2'd1: b = ROW1_BASE;
			2'd2: b = ROW2_BASE;
			default: b = ROW3_BASE;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] cursor_byte(input logic [1:0] mode);
		logic [7:0] b;
		case (mode)
			CMODE_HIDE: b = DISPLAY_OFF_CUR;
			CMODE_SHOW: b = DISPLAY_ON_CUR;
			default:    b = DISPLAY_BLINK;
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/char_lcd_nibble_sequencer_top.sv =====
// Character LCD nibble sequencer for a 4-bit bus. An operation is taken when
// start is high and busy is low; it lands in a four-deep job queue, so several
// operations may be issued back to back while earlier ones are still going out.
// Each enable pulse appears on nibble, register_select, long_wait and last for
// exactly one cycle with strobe high, and the receiver cannot stall it. Pulses
// go out one per cycle while a job is queued: a command, data or goto byte as
// its high then low nibble, a nibble command as one pulse, two digits as two bytes,
// init as wake nibbles then setup bytes, all set by the single pulse generator.
// When the queue was empty, a taken operation is registered in the queue and
// then in the output registers before its first pulse is on the ports. busy is
// high only while the queue is full. cursor_mode is written through
// cfg_valid/cfg_data (cfg_ready is always high) and is sampled when an init operation is taken.
module char_lcd_nibble_sequencer_top #(
	parameter int COLUMN_LIMIT = lcdns_pkg::COLUMN_LIMIT_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] operation,
	input  logic [7:0] payload,
	input  logic [4:0] column,
	input  logic [1:0] row,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_data,
	output logic       strobe,
	output logic [3:0] nibble,
	output logic       register_select,
	output logic       long_wait,
	output logic       last
);
	import lcdns_pkg::*;

	logic [1:0]  cursor_mode_q;
	logic        push;
	logic        pop;
	logic        full;
	logic        empty;
	lcdns_desc_t push_desc;
	lcdns_desc_t head_desc;

	assign cfg_ready = 1'b1;
	assign busy      = full;

	// Hold the cursor mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_mode_q <= CMODE_SHOW;
		end else if (cfg_valid && cfg_ready) begin
			cursor_mode_q <= cfg_data;
		end
	end

	lcdns_front #(
		.COLUMN_LIMIT(COLUMN_LIMIT)
	) u_front (
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.payload    (payload),
		.column     (column),
		.row        (row),
		.cursor_mode(cursor_mode_q),
		.push       (push),
		.desc       (push_desc)
	);

	lcdns_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (push_desc),
		.pop   (pop),
		.rdata (head_desc),
		.full  (full),
		.empty (empty)
	);

	lcdns_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid          (!empty),
		.job            (head_desc),
		.pop            (pop),
		.strobe         (strobe),
		.nibble         (nibble),
		.register_select(register_select),
		.long_wait      (long_wait),
		.last           (last)
	);

endmodule

// ===== rtl/lcdns_front.sv =====
module lcdns_front #(
	parameter int COLUMN_LIMIT = lcdns_pkg::COLUMN_LIMIT_DEFAULT
) (
	input  logic                    start,
	input  logic                    busy,
	input  logic [2:0]              operation,
	input  logic [7:0]              payload,
	input  logic [4:0]              column,
	input  logic [1:0]              row,
	input  logic [1:0]              cursor_mode,
	output logic                    push,
	output lcdns_pkg::lcdns_desc_t  desc
);
	import lcdns_pkg::*;

	localparam logic [5:0] LIMIT = 6'(COLUMN_LIMIT);

	logic [15:0] prod;
	logic [4:0]  tens;
	logic [7:0]  units;
	logic        col_ok;
	logic [7:0]  goto_byte;
	logic        known_op;

	// Split the two-digit value by a reciprocal multiply
	assign prod  = 16'(payload) * 16'(RECIP_TEN);
	assign tens  = prod[RECIP_SHIFT +: 5];
	assign units = payload - {tens, 3'b000} - {2'b00, tens, 1'b0};

	// Form the goto address, adding the column only inside the limit
	assign col_ok    = {1'b0, column} < LIMIT;
	assign goto_byte = row_base(row) + (col_ok ? {3'b000, column} : 8'd0);

	assign known_op = (operation == OP_COMMAND) || (operation == OP_DATA) ||
		(operation == OP_NIBBLE) || (operation == OP_INIT) ||
		(operation == OP_GOTO) || (operation == OP_DIGITS);

	// Queue a job for every known operation; drop the rest
	assign push = start && !busy && known_op;

	// Classify the operation into a job
	always_comb begin
		desc = '0;
		case (operation)
			OP_COMMAND: begin
				desc.kind   = KIND_BYTE;
				desc.byte_a = payload;
			end
			OP_DATA: begin
				desc.kind   = KIND_BYTE;
				desc.rs     = 1'b1;
				desc.byte_a = payload;
			end
			OP_NIBBLE: begin
				desc.kind   = KIND_NIBBLE;
				desc.byte_a = {4'h0, payload[3:0]};
			end
			OP_INIT: begin
				desc.kind   = KIND_INIT;
				desc.byte_a = cursor_byte(cursor_mode);
			end
			OP_GOTO: begin
				desc.kind   = KIND_BYTE;
				desc.byte_a = goto_byte;
			end
			OP_DIGITS: begin
				desc.kind   = KIND_DIGITS;
				desc.rs     = 1'b1;
				desc.byte_a = {3'b000, tens} + DIGIT_BASE;
				desc.byte_b = units + DIGIT_BASE;
			end
			default: begin
				desc = '0;
			end
		endcase
	end

endmodule

// ===== rtl/lcdns_queue.sv =====
module lcdns_queue #(
	parameter int DEPTH = lcdns_pkg::QUEUE_DEPTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  lcdns_pkg::lcdns_desc_t  wdata,
	input  logic                    pop,
	output lcdns_pkg::lcdns_desc_t  rdata,
	output logic                    full,
	output logic                    empty
);
	import lcdns_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	lcdns_desc_t       mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;

	assign full  = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	// Store the pushed word
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and track fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/lcdns_back.sv =====
module lcdns_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid,
	input  lcdns_pkg::lcdns_desc_t  job,
	output logic                    pop,
	output logic                    strobe,
	output logic [3:0]              nibble,
	output logic                    register_select,
	output logic                    long_wait,
	output logic                    last
);
	import lcdns_pkg::*;

	localparam logic [3:0] BYTE_LAST   = 4'd1;
	localparam logic [3:0] NIBBLE_LAST = 4'd0;
	localparam logic [3:0] DIGITS_LAST = 4'd3;
	localparam logic [3:0] INIT_LAST   = 4'd11;
	localparam logic [3:0] INIT_BYTES  = 4'd4;
	localparam logic [3:0] MODE4_STEP  = 4'd3;

	logic [3:0] step_q;
	logic [3:0] last_step;
	logic       is_last;
	logic [7:0] cur_byte;
	logic [3:0] nib_d;
	logic       lw_d;

	logic       strobe_q;
	logic [3:0] nibble_q;
	logic       rs_q;
	logic       lw_q;
	logic       last_q;

	// Final step of each job kind
	always_comb begin
		case (job.kind)
			KIND_BYTE:   last_step = BYTE_LAST;
			KIND_NIBBLE: last_step = NIBBLE_LAST;
			KIND_DIGITS: last_step = DIGITS_LAST;
			default:     last_step = INIT_LAST;
		endcase
	end

	assign is_last = (step_q == last_step);
	assign pop     = valid && is_last;

	// Pick the byte being sent at this step
	always_comb begin
		case (job.kind)
			KIND_DIGITS: cur_byte = step_q[1] ? job.byte_b : job.byte_a;
			KIND_INIT: begin
				case (step_q[3:1])
					3'd2:    cur_byte = FUNCTION_SET;
					3'd3:    cur_byte = job.byte_a;
					3'd4:    cur_byte = ENTRY_MODE;
					default: cur_byte = CLEAR_DISPLAY;
				endcase
			end
			default: cur_byte = job.byte_a;
		endcase
	end

	// Form the pulse: high nibble then low nibble with a long wait
	always_comb begin
		nib_d = step_q[0] ? cur_byte[3:0] : cur_byte[7:4];
		lw_d  = step_q[0];
		if (job.kind == KIND_NIBBLE) begin
			nib_d = job.byte_a[3:0];
			lw_d  = 1'b1;
		end else if ((job.kind == KIND_INIT) && (step_q < INIT_BYTES)) begin
			nib_d = (step_q == MODE4_STEP) ? MODE4_NIBBLE : WAKE_NIBBLE;
			lw_d  = 1'b1;
		end
	end

	// Advance through the job at the queue head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= valid;
			if (pop) begin
				step_q <= '0;
			end else if (valid) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	// Register the result word while a job is at the queue head
	always_ff @(posedge clk) begin
		if (valid) begin
			nibble_q <= nib_d;
			rs_q     <= job.rs;
			lw_q     <= lw_d;
			last_q   <= is_last;
		end
	end

	assign strobe          = strobe_q;
	assign nibble          = nibble_q;
	assign register_select = rs_q;
	assign long_wait       = lw_q;
	assign last            = last_q;

endmodule

// ===== rtl/lcdns_checker.sv =====
module lcdns_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [2:0] operation,
	input logic       strobe,
	input logic       long_wait,
	input logic       last
);
	import lcdns_pkg::*;

	// A high nibble is never the end of an operation
	a_short_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !long_wait |-> !last)
		else $error("pulse without long wait marked last");

	// The low nibble follows its high nibble in the next cycle
	a_low_follows: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !long_wait |=> strobe)
		else $error("low nibble did not follow high nibble");

	// Every operation closes with a long settle wait
	a_last_waits: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> long_wait)
		else $error("final pulse without long wait");

	// A taken operation is followed by a strobe once it is registered in the queue and then in the output registers
	a_issue_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (operation <= OP_DIGITS) |-> ##2 strobe)
		else $error("no pulse after an accepted operation");

endmodule

bind char_lcd_nibble_sequencer_top lcdns_checker u_checker (.*);
